[rtl/svk_pkg.sv]
// shared types, constants and helper functions for the sph viscosity kernel core
package svk_pkg;

    localparam int FRAC      = 16;
    localparam int CFG_W     = 31;
    localparam int EPS_W     = 16;
    localparam int IDX_W     = 3;
    localparam int HNUM_W    = CFG_W + FRAC;
    localparam int DEN_W     = 62;
    localparam int LIM_W     = 61;
    localparam int PROD_W    = 96;
    localparam int SQ_CELLS  = 32;
    localparam int DIV_CELLS = HNUM_W;
    localparam int MUL_LAT   = 3;

    // pipeline stage numbers, counted in enabled edges after acceptance
    localparam int ST_R      = 2 + SQ_CELLS;
    localparam int ST_D1     = ST_R + 1;
    localparam int ST_D1_OUT = ST_D1 + DIV_CELLS;
    localparam int ST_R3     = ST_R + MUL_LAT + 1;
    localparam int ST_D2     = ST_R3 + 1;
    localparam int ST_D2_OUT = ST_D2 + DIV_CELLS;
    localparam int ST_T1     = ST_R3 + MUL_LAT + 1;
    localparam int ST_SUM    = ST_D2_OUT + 1;
    localparam int ST_G      = ST_SUM + MUL_LAT + 1;
    localparam int ST_LAST   = ST_G + MUL_LAT + 1;

    localparam logic [LIM_W-1:0]  LIM      = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] LIM_WIDE = PROD_W'(LIM);
    localparam logic [PROD_W-1:0] POS_MAX  = PROD_W'(32'h7fff_ffff);
    localparam logic [PROD_W-1:0] NEG_MAG  = PROD_W'(32'h8000_0000);
    localparam logic [63:0]       ONE      = 64'd1 << FRAC;

    typedef enum logic [IDX_W-1:0] {
        REG_SUPPORT_RADIUS  = 3'd0,
        REG_KERNEL_COEFF    = 3'd1,
        REG_INV_RADIUS_SQ   = 3'd2,
        REG_INV_RADIUS_CUBE = 3'd3,
        REG_GUARD_EPSILON   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] r2;
        logic [63:0] rest;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [HNUM_W-1:0] rem;
        logic [HNUM_W-1:0] q;
        logic [HNUM_W-1:0] nsh;
    } div_t;

    typedef struct packed {
        logic [31:0] kernel_value;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic [31:0] laplacian;
        logic        outside_support;
    } res_t;

    function automatic logic [LIM_W-1:0] clamp_lim(input logic [PROD_W-1:0] v);
        clamp_lim = (v > LIM_WIDE) ? LIM : v[LIM_W-1:0];
    endfunction

    function automatic logic [31:0] sat_q(input logic [PROD_W-1:0] mag, input logic neg);
        if (neg)
        begin
            sat_q = (mag >= NEG_MAG) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end
        else
        begin
            sat_q = (mag > POS_MAX) ? 32'h7fff_ffff : mag[31:0];
        end
    endfunction

    function automatic logic [LIM_W-1:0] quot_fix(input div_t d);
        quot_fix = (d.den == '0) ? LIM : LIM_W'(d.q);
    endfunction

endpackage

[rtl/sph_viscosity_kernel_eval_core.sv]
// top level of the sph viscosity kernel evaluator: pipeline, config registers, output skid
// throughput: one word per cycle while the skid word is empty; the sqrt chain (32 cells) and the two divider
//   chains (47 cells each) hand their data along on every enabled edge, so nothing iterates
// the output register plus one skid word keep input open while a result waits
// reset (rst_n low, async): valids and skid cleared, registers return to h=A=1/h2=1/h3=1.0, eps=1 lsb
module sph_viscosity_kernel_eval_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [svk_pkg::IDX_W-1:0]   cfg_index,
    input  logic [svk_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          offset_x,
    input  logic signed [31:0]          offset_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          kernel_value,
    output logic signed [31:0]          grad_x,
    output logic signed [31:0]          grad_y,
    output logic signed [31:0]          laplacian,
    output logic                        outside_support
);
    import svk_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] radius_reg;
    logic [CFG_W-1:0] coeff_reg;
    logic [CFG_W-1:0] isq_reg;
    logic [CFG_W-1:0] icube_reg;
    logic [EPS_W-1:0] eps_reg;

    // values derived from configuration, refreshed every cycle
    logic [61:0]       h2_next;
    logic [61:0]       h2_reg;
    logic [70:0]       h2x101_reg;
    logic [32:0]       icube3;
    logic [HNUM_W-1:0] hnum;

    // global advance: the whole pipe moves unless the skid word is occupied
    logic en;

    logic [ST_LAST:0] v_reg;

    // operand delay lines
    logic [31:0]      x_dly_reg   [ST_LAST];
    logic [31:0]      y_dly_reg   [ST_LAST];
    logic             os_dly_reg  [ST_LAST-2];
    logic [31:0]      lap_dly_reg [ST_LAST-ST_R3+1];
    logic             lneg_dly_reg[MUL_LAT];
    logic [LIM_W-1:0] t2_dly_reg  [ST_D2_OUT-ST_R3+1];
    logic [LIM_W-1:0] u1_dly_reg  [ST_D2_OUT-ST_R3+1];
    logic [LIM_W-1:0] t1_dly_reg  [ST_D2_OUT-ST_T1+1];
    logic [LIM_W-1:0] t3_dly_reg  [ST_D2_OUT-ST_D1_OUT];
    logic             sneg_dly_reg [MUL_LAT];
    logic             gsneg_dly_reg[MUL_LAT];
    logic [31:0]      w_dly_reg   [ST_LAST-ST_G+1];
    logic             gneg_dly_reg[MUL_LAT+1];

    // front end
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] sqx_reg;
    logic [63:0] sqy_reg;
    logic [63:0] r2_reg;
    logic [70:0] r2x100;

    // sqrt and divider chains
    sqrt_t sq_chain [SQ_CELLS+1];
    div_t  d1_chain [DIV_CELLS+1];
    div_t  d2_chain [DIV_CELLS+1];
    div_t  d1_in_reg;
    div_t  d2_in_reg;

    logic [31:0] r_w;
    logic [63:0] r2_w;
    logic [33:0] hr;
    logic [33:0] hr_mag;

    logic [PROD_W-1:0] p_r3, p_t2, p_u1, p_lap, p_t1, p_w, p_g, p_gx, p_gy;

    logic [LIM_W-1:0] r3_reg;
    logic [63:0]      s_next;
    logic [63:0]      gs_next;
    logic [63:0]      s_reg;
    logic [63:0]      gs_reg;
    logic [63:0]      s_mag;
    logic [63:0]      gs_mag;
    logic [LIM_W-1:0] gmag_next;
    logic [LIM_W-1:0] gmag_reg;
    logic [31:0]      gx_reg;
    logic [31:0]      gy_reg;
    logic [31:0]      gax;
    logic [31:0]      gay;

    // output side
    res_t pipe_res;
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_full_reg;
    logic take;
    logic deliver;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= CFG_W'(ONE);
            coeff_reg  <= CFG_W'(ONE);
            isq_reg    <= CFG_W'(ONE);
            icube_reg  <= CFG_W'(ONE);
            eps_reg    <= EPS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SUPPORT_RADIUS:  radius_reg <= cfg_data;
                REG_KERNEL_COEFF:    coeff_reg  <= cfg_data;
                REG_INV_RADIUS_SQ:   isq_reg    <= cfg_data;
                REG_INV_RADIUS_CUBE: icube_reg  <= cfg_data;
                REG_GUARD_EPSILON:   eps_reg    <= cfg_data[EPS_W-1:0];
                default:             ;
            endcase
        end
    end

    // h squared and 101 h squared for the support test, registered in h2_reg and then h2x101_reg
    assign h2_next = radius_reg * radius_reg;
    assign icube3  = {2'b00, icube_reg} + {1'b0, icube_reg, 1'b0};
    assign hnum    = {radius_reg, {FRAC{1'b0}}};

    always_ff @(posedge clk)
    begin
        h2_reg     <= h2_next;
        h2x101_reg <= (71'(h2_reg) << 6) + (71'(h2_reg) << 5) + (71'(h2_reg) << 2)
                      + 71'(h2_reg);
    end

    // ---------------- handshake ----------------
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST_LAST-1:0], in_valid};
        end
    end

    // ---------------- front end: |x|^2 + |y|^2 ----------------
    assign ax     = x_dly_reg[0][31] ? (32'd0 - x_dly_reg[0]) : x_dly_reg[0];
    assign ay     = y_dly_reg[0][31] ? (32'd0 - y_dly_reg[0]) : y_dly_reg[0];
    assign r2x100 = (71'(r2_reg) << 6) + (71'(r2_reg) << 5) + (71'(r2_reg) << 2);

    // ---------------- square root chain ----------------
    assign sq_chain[0] = '{r2: r2_reg, rest: r2_reg, rem: '0, root: '0};

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sq
        svk_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq_chain[k]),
            .d_out (sq_chain[k+1])
        );
    end

    assign r_w    = sq_chain[SQ_CELLS].root;
    assign r2_w   = sq_chain[SQ_CELLS].r2;
    assign hr     = {3'b000, radius_reg} - {2'b00, r_w};
    assign hr_mag = hr[33] ? (34'd0 - hr) : hr;

    // products that need r only
    svk_mul u_mul_r3  (.clk(clk), .en(en), .a(r2_w), .b(r_w), .p(p_r3));
    svk_mul u_mul_t2  (.clk(clk), .en(en), .a(r2_w), .b({1'b0, isq_reg}), .p(p_t2));
    svk_mul u_mul_u1  (.clk(clk), .en(en), .a(64'(icube3)), .b(r_w), .p(p_u1));
    svk_mul u_mul_lap (.clk(clk), .en(en), .a(64'(hr_mag)), .b({1'b0, coeff_reg}), .p(p_lap));

    // r cubed feeds the first kernel term
    svk_mul u_mul_t1  (.clk(clk), .en(en), .a(64'(r3_reg)), .b({1'b0, icube_reg}), .p(p_t1));

    // ---------------- divider chains: h/(2r+eps) and h/(2r^3+eps) ----------------
    assign d1_chain[0] = d1_in_reg;
    assign d2_chain[0] = d2_in_reg;

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        svk_div_cell u_cell1 (
            .clk   (clk),
            .en    (en),
            .d_in  (d1_chain[k]),
            .d_out (d1_chain[k+1])
        );
        svk_div_cell u_cell2 (
            .clk   (clk),
            .en    (en),
            .d_in  (d2_chain[k]),
            .d_out (d2_chain[k+1])
        );
    end

    // ---------------- term sums ----------------
    always_comb
    begin
        s_next  = 64'(t2_dly_reg[ST_D2_OUT-ST_R3]) + 64'(t3_dly_reg[ST_D2_OUT-ST_D1_OUT-1])
                  - 64'(t1_dly_reg[ST_D2_OUT-ST_T1]) - ONE;
        gs_next = 64'({isq_reg, 1'b0}) - 64'(u1_dly_reg[ST_D2_OUT-ST_R3])
                  - 64'(quot_fix(d2_chain[DIV_CELLS]));
    end

    assign s_mag  = s_reg[63] ? (64'd0 - s_reg) : s_reg;
    assign gs_mag = gs_reg[63] ? (64'd0 - gs_reg) : gs_reg;

    svk_mul u_mul_w (.clk(clk), .en(en), .a(s_mag),  .b({1'b0, coeff_reg}), .p(p_w));
    svk_mul u_mul_g (.clk(clk), .en(en), .a(gs_mag), .b({1'b0, coeff_reg}), .p(p_g));

    // gradient factor, saturated to the internal limit
    assign gmag_next = clamp_lim(p_g >> FRAC);

    assign gax = x_dly_reg[ST_G][31] ? (32'd0 - x_dly_reg[ST_G]) : x_dly_reg[ST_G];
    assign gay = y_dly_reg[ST_G][31] ? (32'd0 - y_dly_reg[ST_G]) : y_dly_reg[ST_G];

    svk_mul u_mul_gx (.clk(clk), .en(en), .a(64'(gmag_reg)), .b(gax), .p(p_gx));
    svk_mul u_mul_gy (.clk(clk), .en(en), .a(64'(gmag_reg)), .b(gay), .p(p_gy));

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_dly_reg[0] <= offset_x;
            y_dly_reg[0] <= offset_y;
            for (int i = 1; i < ST_LAST; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
            end

            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            r2_reg  <= sqx_reg + sqy_reg;

            // support test: 100 r^2 > 101 h^2, exact
            os_dly_reg[0] <= (r2x100 > h2x101_reg);
            for (int i = 1; i < ST_LAST - 2; i++)
            begin
                os_dly_reg[i] <= os_dly_reg[i-1];
            end

            lneg_dly_reg[0]  <= hr[33];
            sneg_dly_reg[0]  <= s_reg[63];
            gsneg_dly_reg[0] <= gs_reg[63];
            for (int i = 1; i < MUL_LAT; i++)
            begin
                lneg_dly_reg[i]  <= lneg_dly_reg[i-1];
                sneg_dly_reg[i]  <= sneg_dly_reg[i-1];
                gsneg_dly_reg[i] <= gsneg_dly_reg[i-1];
            end

            d1_in_reg <= '{den: DEN_W'({r_w, 1'b0}) + DEN_W'(eps_reg),
                           rem: '0, q: '0, nsh: hnum};

            r3_reg        <= clamp_lim(p_r3 >> (2 * FRAC));
            t2_dly_reg[0] <= clamp_lim(p_t2 >> (2 * FRAC));
            u1_dly_reg[0] <= clamp_lim(p_u1 >> (FRAC + 1));
            for (int i = 1; i < ST_D2_OUT - ST_R3 + 1; i++)
            begin
                t2_dly_reg[i] <= t2_dly_reg[i-1];
                u1_dly_reg[i] <= u1_dly_reg[i-1];
            end

            lap_dly_reg[0] <= sat_q(p_lap >> FRAC, lneg_dly_reg[MUL_LAT-1]);
            for (int i = 1; i < ST_LAST - ST_R3 + 1; i++)
            begin
                lap_dly_reg[i] <= lap_dly_reg[i-1];
            end

            d2_in_reg <= '{den: {r3_reg, 1'b0} + DEN_W'(eps_reg),
                           rem: '0, q: '0, nsh: hnum};

            t1_dly_reg[0] <= clamp_lim(p_t1 >> (FRAC + 1));
            for (int i = 1; i < ST_D2_OUT - ST_T1 + 1; i++)
            begin
                t1_dly_reg[i] <= t1_dly_reg[i-1];
            end

            t3_dly_reg[0] <= quot_fix(d1_chain[DIV_CELLS]);
            for (int i = 1; i < ST_D2_OUT - ST_D1_OUT; i++)
            begin
                t3_dly_reg[i] <= t3_dly_reg[i-1];
            end

            s_reg  <= s_next;
            gs_reg <= gs_next;

            w_dly_reg[0] <= sat_q(p_w >> FRAC, sneg_dly_reg[MUL_LAT-1]);
            for (int i = 1; i < ST_LAST - ST_G + 1; i++)
            begin
                w_dly_reg[i] <= w_dly_reg[i-1];
            end

            // a zero factor carries no sign
            gmag_reg        <= gmag_next;
            gneg_dly_reg[0] <= gsneg_dly_reg[MUL_LAT-1] && (gmag_next != '0);
            for (int i = 1; i < MUL_LAT + 1; i++)
            begin
                gneg_dly_reg[i] <= gneg_dly_reg[i-1];
            end

            gx_reg <= sat_q(p_gx >> FRAC, x_dly_reg[ST_LAST-1][31] ^ gneg_dly_reg[MUL_LAT]);
            gy_reg <= sat_q(p_gy >> FRAC, y_dly_reg[ST_LAST-1][31] ^ gneg_dly_reg[MUL_LAT]);
        end
    end

    // ---------------- output register and skid word ----------------
    assign pipe_res = '{kernel_value:    w_dly_reg[ST_LAST-ST_G],
                        grad_x:          gx_reg,
                        grad_y:          gy_reg,
                        laplacian:       lap_dly_reg[ST_LAST-ST_R3],
                        outside_support: os_dly_reg[ST_LAST-3]};

    assign take    = out_valid_reg && !out_stall;
    assign deliver = en && v_reg[ST_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (deliver)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (deliver)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= pipe_res;
            end
            else
            begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign kernel_value    = out_reg.kernel_value;
    assign grad_x          = out_reg.grad_x;
    assign grad_y          = out_reg.grad_y;
    assign laplacian       = out_reg.laplacian;
    assign outside_support = out_reg.outside_support;

endmodule

[rtl/svk_sqrt_cell.sv]
// one cell of the square root chain: settles one root bit per cycle while en is high
module svk_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  svk_pkg::sqrt_t d_in,
    output svk_pkg::sqrt_t d_out
);
    import svk_pkg::*;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;
    sqrt_t       sq_next;
    sqrt_t       sq_reg;

    always_comb
    begin
        rem_sh          = {d_in.rem, d_in.rest[63:62]};
        trial           = {2'b00, d_in.root, 2'b01};
        ge              = (rem_sh >= trial);
        sq_next.r2      = d_in.r2;
        sq_next.rest    = {d_in.rest[61:0], 2'b00};
        sq_next.rem     = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        sq_next.root    = {d_in.root[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign d_out = sq_reg;

endmodule

[rtl/svk_div_cell.sv]
// one cell of the restoring divider chain: settles one quotient bit per cycle while en is high
module svk_div_cell (
    input  logic          clk,
    input  logic          en,
    input  svk_pkg::div_t d_in,
    output svk_pkg::div_t d_out
);
    import svk_pkg::*;

    logic [HNUM_W:0] rem_sh;
    logic [HNUM_W:0] diff;
    logic            ge;
    div_t            dv_next;
    div_t            dv_reg;

    always_comb
    begin
        rem_sh       = {d_in.rem, d_in.nsh[HNUM_W-1]};
        ge           = ({(DEN_W-HNUM_W-1)'(0), rem_sh} >= d_in.den);
        diff         = rem_sh - d_in.den[HNUM_W:0];
        dv_next.den  = d_in.den;
        dv_next.rem  = ge ? diff[HNUM_W-1:0] : rem_sh[HNUM_W-1:0];
        dv_next.q    = {d_in.q[HNUM_W-2:0], ge};
        dv_next.nsh  = {d_in.nsh[HNUM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_next;
        end
    end

    assign d_out = dv_reg;

endmodule

[rtl/svk_mul.sv]
// 64 by 32 unsigned multiplier split into two 32 by 32 partial products, three stages
module svk_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [63:0]                 a,
    input  logic [31:0]                 b,
    output logic [svk_pkg::PROD_W-1:0]  p
);
    import svk_pkg::*;

    logic [63:0]       lo_next;
    logic [63:0]       hi_next;
    logic [63:0]       lo_reg;
    logic [31:0]       ahi_reg;
    logic [31:0]       b_reg;
    logic [63:0]       lo2_reg;
    logic [63:0]       hi_reg;
    logic [PROD_W-1:0] p_reg;

    assign lo_next = a[31:0] * b;
    assign hi_next = ahi_reg * b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg  <= lo_next;
            ahi_reg <= a[63:32];
            b_reg   <= b;
            hi_reg  <= hi_next;
            lo2_reg <= lo_reg;
            p_reg   <= {hi_reg, 32'd0} + {32'd0, lo2_reg};
        end
    end

    assign p = p_reg;

endmodule

[rtl/svk_checker.sv]
// port-level checker for the sph viscosity kernel core, bound to the top level
module svk_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [31:0]  kernel_value,
    input logic signed [31:0]  grad_x,
    input logic signed [31:0]  grad_y,
    input logic signed [31:0]  laplacian,
    input logic                outside_support
);

    // a waiting word stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // a waiting word does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kernel_value) && $stable(grad_x)
            && $stable(grad_y) && $stable(laplacian) && $stable(outside_support))
        else $error("stalled output word changed");

    // input only stalls when a result is waiting and was refused
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && $past(out_stall))
        else $error("input stalled without output back pressure");

    // outside the support r >= h, so h-r cannot be positive
    a_lap_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outside_support |-> laplacian[31] || (laplacian == 32'sd0))
        else $error("positive laplacian outside support");

endmodule

bind sph_viscosity_kernel_eval_core svk_checker u_svk_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kernel_value    (kernel_value),
    .grad_x          (grad_x),
    .grad_y          (grad_y),
    .laplacian       (laplacian),
    .outside_support (outside_support)
);
